/* src/mkat_pkg.sv */
// shared constants, types and helpers of the midi key activity tracker
`timescale 1ns / 1ps
`default_nettype none
package mkat_pkg;

  localparam int CHANNELS          = 16;
  localparam int NOTES_PER_CHANNEL = 16;
  localparam int LEVELS            = 16;
  localparam int MAX_RESULTS       = 16;

  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W   = (NOTES_PER_CHANNEL > 1) ? $clog2(NOTES_PER_CHANNEL) : 1;
  localparam int CNT_W   = $clog2(NOTES_PER_CHANNEL + 1);
  localparam int EMIT_W  = $clog2(MAX_RESULTS + 1);
  localparam int ADDR_W  = (CHANNELS * NOTES_PER_CHANNEL > 1) ?
                           $clog2(CHANNELS * NOTES_PER_CHANNEL) : 1;

  localparam logic [6:0] LVL_FULL = 7'(LEVELS - 1);
  localparam logic [6:0] LVL_REL  = 7'(LEVELS - 2);

  localparam logic [1:0] FUNC_MIDI   = 2'd0;
  localparam logic [1:0] FUNC_TICK   = 2'd1;
  localparam logic [1:0] FUNC_RELOAD = 2'd2;

  localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
  localparam logic [3:0] MSG_CTRL     = 4'hb;
  localparam logic [7:0] STATUS_RESET = 8'hfe;
  localparam logic [7:0] CC_NOTES_OFF = 8'h7b;
  localparam logic [7:0] CC_SOUND_OFF = 8'h78;

  localparam logic [1:0] FLAG_PENDING = 2'd1;
  localparam logic [1:0] FLAG_RELOAD  = 2'd2;

  typedef enum logic [2:0] {
    OP_LIGHT,
    OP_REL_KEY,
    OP_REL_CH,
    OP_REL_ALL,
    OP_TICK,
    OP_RELOAD
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EXEC,
    ST_EMIT,
    ST_STORE
  } st_t;

  typedef struct packed {
    op_t             op;
    logic [CH_W-1:0] ch;
    logic [6:0]      note;
    logic [7:0]      frames;
  } cmd_t;

  typedef struct packed {
    logic [3:0] channel;
    logic [6:0] note;
    logic [3:0] level;
    logic       last;
  } res_t;

  function automatic logic [ADDR_W-1:0] slot_addr(logic [CH_W-1:0] ch,
                                                  logic [IDX_W-1:0] idx);
    return ADDR_W'(ch) * ADDR_W'(NOTES_PER_CHANNEL) + ADDR_W'(idx);
  endfunction

endpackage
`default_nettype wire

/* src/mkat_front.sv */
// input decoder and two-entry command queue
`timescale 1ns / 1ps
`default_nettype none
module mkat_front (
  input  wire                logic       clk,
  input  wire                logic       rst,
  input  wire                logic       push,
  output                     logic       full,
  input  wire                logic [1:0] func,
  input  wire                logic [7:0] status_byte,
  input  wire                logic [7:0] data_first,
  input  wire                logic [7:0] data_second,
  input  wire                logic [3:0] tick_channel,
  input  wire                logic [7:0] frames,
  output                     logic       cmd_valid,
  output mkat_pkg::cmd_t                 cmd,
  input  wire                logic       cmd_pop
);

  mkat_pkg::cmd_t dec;
  logic           keep;
  mkat_pkg::cmd_t q [2];
  logic           wp, rp;
  logic [1:0]     cnt;
  logic           enq, deq;

  always_comb begin
    dec.op     = mkat_pkg::OP_RELOAD;
    dec.ch     = status_byte[mkat_pkg::CH_W-1:0];
    dec.note   = data_first[6:0];
    dec.frames = frames;
    keep       = 1'b0;
    unique case (func)
      mkat_pkg::FUNC_MIDI: begin
        if (status_byte == mkat_pkg::STATUS_RESET) begin
          dec.op = mkat_pkg::OP_REL_ALL;
          keep   = 1'b1;
        end else if (5'(status_byte[3:0]) < 5'(mkat_pkg::CHANNELS)) begin
          case (status_byte[7:4])
            mkat_pkg::MSG_NOTE_OFF: begin
              dec.op = mkat_pkg::OP_REL_KEY;
              keep   = 1'b1;
            end
            mkat_pkg::MSG_NOTE_ON: begin
              dec.op = (data_second[6:0] != 7'd0) ? mkat_pkg::OP_LIGHT
                                                  : mkat_pkg::OP_REL_KEY;
              keep   = 1'b1;
            end
            mkat_pkg::MSG_CTRL: begin
              dec.op = mkat_pkg::OP_REL_CH;
              keep   = (data_first == mkat_pkg::CC_NOTES_OFF) ||
                       (data_first == mkat_pkg::CC_SOUND_OFF);
            end
            default: keep = 1'b0;
          endcase
        end
      end
      mkat_pkg::FUNC_TICK: begin
        dec.op = mkat_pkg::OP_TICK;
        dec.ch = tick_channel[mkat_pkg::CH_W-1:0];
        keep   = 5'(tick_channel) < 5'(mkat_pkg::CHANNELS);
      end
      mkat_pkg::FUNC_RELOAD: begin
        dec.op = mkat_pkg::OP_RELOAD;
        keep   = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];
  assign enq       = push && !full && keep;
  assign deq       = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wp] <= dec;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (enq) begin
        wp <= ~wp;
      end
      if (deq) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(enq) - 2'(deq);
    end
  end

endmodule
`default_nettype wire

/* src/mkat_outq.sv */
// two-entry result queue
`timescale 1ns / 1ps
`default_nettype none
module mkat_outq (
  input  wire                logic       clk,
  input  wire                logic       rst,
  input  wire                logic       res_push,
  input  mkat_pkg::res_t                 res_item,
  output                     logic       res_full,
  output                     logic       empty,
  input  wire                logic       pop,
  output                     logic [3:0] out_channel,
  output                     logic [6:0] out_note,
  output                     logic [3:0] out_level,
  output                     logic       out_last
);

  mkat_pkg::res_t q [2];
  logic           wp, rp;
  logic [1:0]     cnt;
  logic           enq, deq;

  assign res_full    = (cnt == 2'd2);
  assign empty       = (cnt == 2'd0);
  assign enq         = res_push && !res_full;
  assign deq         = pop && !empty;
  assign out_channel = q[rp].channel;
  assign out_note    = q[rp].note;
  assign out_level   = q[rp].level;
  assign out_last    = q[rp].last;

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wp] <= res_item;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (enq) begin
        wp <= ~wp;
      end
      if (deq) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(enq) - 2'(deq);
    end
  end

endmodule
`default_nettype wire

/* src/mkat_back.sv */
// key list engine: per-channel load, update, redraw and write-back
`timescale 1ns / 1ps
`default_nettype none
module mkat_back (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic cmd_valid,
  input  mkat_pkg::cmd_t           cmd,
  output                     logic cmd_pop,
  output                     logic res_push,
  output mkat_pkg::res_t           res_item,
  input  wire                logic res_full
);

  localparam int N = mkat_pkg::NOTES_PER_CHANNEL;
  localparam int C = mkat_pkg::CHANNELS;

  mkat_pkg::st_t state, state_next;

  logic [14:0] mem [C*N];
  logic [14:0] mem_rdata;
  logic                       mem_re, mem_we;
  logic [mkat_pkg::ADDR_W-1:0] mem_raddr, mem_waddr;
  logic [14:0]                mem_wdata;

  logic [mkat_pkg::CNT_W-1:0] entry_count [C];
  logic [1:0]                 channel_flags [C];

  mkat_pkg::cmd_t             cur;
  logic [mkat_pkg::CH_W-1:0]  ch_cur;
  logic [mkat_pkg::CNT_W-1:0] k, j, cnt_old, cnt_new;
  logic                       ld_vld;
  logic [mkat_pkg::IDX_W-1:0] ld_idx;
  logic [6:0]                 row_note [N];
  logic [7:0]                 row_lvl [N];
  logic [N-1:0]               hmask;
  logic [mkat_pkg::EMIT_W-1:0] emitted;

  logic [mkat_pkg::CNT_W-1:0] cnt_sel, wl;
  logic [1:0]                 flags_sel;
  logic                       idle_skip;

  logic [6:0]                 x_note [N];
  logic [7:0]                 x_lvl [N];
  logic [N-1:0]               x_hmask, match;
  logic [mkat_pkg::CNT_W-1:0] x_cnt;
  logic [1:0]                 x_flags;
  logic                       found;
  logic [mkat_pkg::IDX_W-1:0] fidx;
  logic                       later_any, emit_ok, keep_entry;
  logic [mkat_pkg::IDX_W-1:0] e_idx, k_idx;

  assign cnt_sel   = entry_count[ch_cur];
  assign flags_sel = channel_flags[ch_cur];
  assign wl        = (cur.op == mkat_pkg::OP_TICK) ? cnt_old : cnt_new;
  assign idle_skip = (cmd.op == mkat_pkg::OP_RELOAD) ||
                     ((cmd.op == mkat_pkg::OP_TICK) && (channel_flags[cmd.ch] == 2'd0));
  assign e_idx     = k[mkat_pkg::IDX_W-1:0];
  assign k_idx     = k[mkat_pkg::IDX_W-1:0];

  // update of the loaded row
  always_comb begin
    match = '0;
    for (int i = 0; i < N; i++) begin
      match[i] = (i < int'(cnt_sel)) && (row_note[i] == cur.note);
    end
    found = |match;
    fidx  = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (match[i]) begin
        fidx = mkat_pkg::IDX_W'(i);
      end
    end
    x_cnt   = cnt_sel;
    x_flags = flags_sel;
    x_hmask = '0;
    for (int i = 0; i < N; i++) begin
      x_note[i] = row_note[i];
      x_lvl[i]  = row_lvl[i];
    end
    case (cur.op)
      mkat_pkg::OP_LIGHT: begin
        if (found) begin
          for (int i = 0; i < N; i++) begin
            if (i + 1 == int'(cnt_sel)) begin
              x_note[i] = cur.note;
              x_lvl[i]  = {1'b1, mkat_pkg::LVL_FULL};
            end else if ((i + 1 < N) && (i >= int'(fidx)) && (i + 1 < int'(cnt_sel))) begin
              x_note[i] = row_note[(i + 1) % N];
              x_lvl[i]  = row_lvl[(i + 1) % N];
            end
          end
          x_flags = flags_sel | mkat_pkg::FLAG_PENDING;
        end else if (int'(cnt_sel) < N) begin
          for (int i = 0; i < N; i++) begin
            if (i == int'(cnt_sel)) begin
              x_note[i] = cur.note;
              x_lvl[i]  = {1'b1, mkat_pkg::LVL_FULL};
            end
          end
          x_cnt   = cnt_sel + 1'b1;
          x_flags = flags_sel | mkat_pkg::FLAG_PENDING;
        end
      end
      mkat_pkg::OP_REL_KEY: begin
        for (int i = 0; i < N; i++) begin
          if (found && (i == int'(fidx))) begin
            x_lvl[i] = {1'b1, mkat_pkg::LVL_REL};
          end
        end
        if (found) begin
          x_flags = flags_sel | mkat_pkg::FLAG_PENDING;
        end
      end
      mkat_pkg::OP_REL_CH, mkat_pkg::OP_REL_ALL: begin
        for (int i = 0; i < N; i++) begin
          if ((i < int'(cnt_sel)) && (row_lvl[i][6:0] >= mkat_pkg::LVL_FULL)) begin
            x_lvl[i] = {1'b1, mkat_pkg::LVL_REL};
            x_flags  = flags_sel | mkat_pkg::FLAG_PENDING;
          end
        end
      end
      mkat_pkg::OP_TICK: begin
        x_flags = 2'd0;
        for (int i = 0; i < N; i++) begin
          if ((i < int'(cnt_sel)) && (row_lvl[i][7] || flags_sel[1])) begin
            x_hmask[i] = 1'b1;
            x_lvl[i]   = {1'b0, row_lvl[i][6:0]};
            if (row_lvl[i][6:0] < mkat_pkg::LVL_FULL) begin
              if ({1'b0, row_lvl[i][6:0]} > cur.frames) begin
                x_lvl[i] = {1'b1, row_lvl[i][6:0] - cur.frames[6:0]};
                x_flags  = mkat_pkg::FLAG_PENDING;
              end else begin
                x_lvl[i] = 8'd0;
              end
            end
          end
        end
      end
      default: x_cnt = cnt_sel;
    endcase
  end

  always_comb begin
    later_any = 1'b0;
    for (int i = 0; i < N; i++) begin
      if ((i > int'(k)) && hmask[i]) begin
        later_any = 1'b1;
      end
    end
  end

  assign emit_ok    = (int'(k) < N) && hmask[e_idx] &&
                      (int'(emitted) < mkat_pkg::MAX_RESULTS);
  assign keep_entry = (cur.op != mkat_pkg::OP_TICK) || (row_lvl[k_idx] != 8'd0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mkat_pkg::ST_IDLE: begin
        if (cmd_valid && !idle_skip) begin
          state_next = mkat_pkg::ST_LOAD;
        end
      end
      mkat_pkg::ST_LOAD: begin
        if (k >= cnt_sel) begin
          state_next = mkat_pkg::ST_EXEC;
        end
      end
      mkat_pkg::ST_EXEC: begin
        state_next = (cur.op == mkat_pkg::OP_TICK) ? mkat_pkg::ST_EMIT : mkat_pkg::ST_STORE;
      end
      mkat_pkg::ST_EMIT: begin
        if (int'(k) >= N) begin
          state_next = mkat_pkg::ST_STORE;
        end
      end
      mkat_pkg::ST_STORE: begin
        if (k >= wl) begin
          if ((cur.op == mkat_pkg::OP_REL_ALL) && (int'(ch_cur) != C - 1)) begin
            state_next = mkat_pkg::ST_LOAD;
          end else begin
            state_next = mkat_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = mkat_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop   = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_raddr = mkat_pkg::slot_addr(ch_cur, k_idx);
    mem_waddr = mkat_pkg::slot_addr(ch_cur, j[mkat_pkg::IDX_W-1:0]);
    mem_wdata = {row_note[k_idx], row_lvl[k_idx]};
    res_push  = 1'b0;
    res_item.channel = 4'(ch_cur);
    res_item.note    = row_note[e_idx];
    res_item.level   = row_lvl[e_idx][3:0];
    res_item.last    = !later_any || (int'(emitted) == mkat_pkg::MAX_RESULTS - 1);
    unique case (state)
      mkat_pkg::ST_IDLE:  cmd_pop  = cmd_valid;
      mkat_pkg::ST_LOAD:  mem_re   = (k < cnt_sel);
      mkat_pkg::ST_EMIT:  res_push = emit_ok && !res_full;
      mkat_pkg::ST_STORE: mem_we   = (k < wl) && keep_entry;
      default:            cmd_pop  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= mkat_pkg::ST_IDLE;
      ld_vld <= 1'b0;
      ch_cur <= '0;
      for (int c = 0; c < C; c++) begin
        entry_count[c]   <= '0;
        channel_flags[c] <= mkat_pkg::FLAG_RELOAD;
      end
    end else begin
      state  <= state_next;
      ld_vld <= mem_re;
      ld_idx <= k_idx;
      if (ld_vld) begin
        row_note[ld_idx] <= mem_rdata[14:8];
        row_lvl[ld_idx]  <= mem_rdata[7:0];
      end
      unique case (state)
        mkat_pkg::ST_IDLE: begin
          if (cmd_valid) begin
            if (cmd.op == mkat_pkg::OP_RELOAD) begin
              for (int c = 0; c < C; c++) begin
                channel_flags[c] <= mkat_pkg::FLAG_RELOAD;
              end
            end
            cur    <= cmd;
            ch_cur <= (cmd.op == mkat_pkg::OP_REL_ALL) ? '0 : cmd.ch;
            k      <= '0;
          end
        end
        mkat_pkg::ST_LOAD: begin
          if (k < cnt_sel) begin
            k <= k + 1'b1;
          end
        end
        mkat_pkg::ST_EXEC: begin
          for (int i = 0; i < N; i++) begin
            row_note[i] <= x_note[i];
            row_lvl[i]  <= x_lvl[i];
          end
          hmask                 <= x_hmask;
          cnt_old               <= cnt_sel;
          cnt_new               <= x_cnt;
          channel_flags[ch_cur] <= x_flags;
          emitted               <= '0;
          k                     <= '0;
          j                     <= '0;
        end
        mkat_pkg::ST_EMIT: begin
          if (int'(k) >= N) begin
            k <= '0;
          end else if (!emit_ok || !res_full) begin
            k <= k + 1'b1;
            if (emit_ok) begin
              emitted <= emitted + 1'b1;
            end
          end
        end
        mkat_pkg::ST_STORE: begin
          if (k < wl) begin
            k <= k + 1'b1;
            if (keep_entry) begin
              j <= j + 1'b1;
            end
          end else begin
            entry_count[ch_cur] <= j;
            ch_cur              <= ch_cur + 1'b1;
            k                   <= '0;
          end
        end
        default: k <= '0;
      endcase
    end
  end

  a_emit_only_tick: assert property (@(posedge clk) disable iff (rst)
    (state == mkat_pkg::ST_EMIT) |-> (cur.op == mkat_pkg::OP_TICK))
    else $error("redraw phase outside a tick");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(cnt_sel) <= N)
    else $error("key list longer than its store");

  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    (state == mkat_pkg::ST_STORE) |-> (j <= k))
    else $error("write pointer ahead of read pointer");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (state == mkat_pkg::ST_IDLE))
    else $error("command taken while busy");

endmodule
`default_nettype wire

/* src/midi_key_activity_tracker.sv */
// top level of the midi key activity tracker
// a transaction loads the key list of its channel, updates it and writes it back, and a tick
//   also scans the list to redraw its keys, a scan that result back-pressure can stall
// a release of all keys on status 0xfe runs the load, update and write-back for every channel in turn
// the back engine takes a new command only when idle, after its sweep of the key store is done
// reset: all lists empty, every channel marked for reload, both queues empty
`timescale 1ns / 1ps
`default_nettype none
module midi_key_activity_tracker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output      logic       full,
  input  wire logic [1:0] func,
  input  wire logic [7:0] status_byte,
  input  wire logic [7:0] data_first,
  input  wire logic [7:0] data_second,
  input  wire logic [3:0] tick_channel,
  input  wire logic [7:0] frames,
  output      logic       empty,
  input  wire logic       pop,
  output      logic [3:0] out_channel,
  output      logic [6:0] out_note,
  output      logic [3:0] out_level,
  output      logic       out_last
);

  logic           cmd_valid, cmd_pop, res_push, res_full;
  mkat_pkg::cmd_t cmd;
  mkat_pkg::res_t res_item;

  mkat_front u_front (
    .clk, .rst, .push, .full, .func, .status_byte, .data_first, .data_second,
    .tick_channel, .frames, .cmd_valid, .cmd, .cmd_pop
  );

  mkat_back u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_pop, .res_push, .res_item, .res_full
  );

  mkat_outq u_outq (
    .clk, .rst, .res_push, .res_item, .res_full, .empty, .pop,
    .out_channel, .out_note, .out_level, .out_last
  );

endmodule
`default_nettype wire
